// ===== rtl/wildcard_sequence_trigger_macros.svh =====
// Assertion macros shared by the wildcard sequence trigger checker.
// No dependencies; included by name from the files that assert.
`ifndef WILDCARD_SEQUENCE_TRIGGER_MACROS_SVH
`define WILDCARD_SEQUENCE_TRIGGER_MACROS_SVH

// Concurrent property on a clock, disabled while reset is asserted.
`define WST_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies another in the following cycle.
`define WST_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/wst_pkg.sv =====
// Shared constants, types and functions of the wildcard sequence trigger.
// No dependencies; used by the interfaces, cells, decoder and top level.
`default_nettype none

package wst_pkg;

	localparam int PATTERN_LENGTH = 10;
	localparam int FIXED_PART     = 6;
	localparam int WILD_LEN       = PATTERN_LENGTH - FIXED_PART;
	localparam int BYTE_W         = 8;
	localparam int RES_W          = 15;
	localparam int ACC_W          = 14;
	localparam int COUNT_W        = $clog2(PATTERN_LENGTH + 1);

	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_WILD  = 8'h23;

	// "system####", oldest position first.
	localparam logic [BYTE_W-1:0] PATTERN_TEXT [PATTERN_LENGTH] = '{
		8'h73, 8'h79, 8'h73, 8'h74, 8'h65, 8'h6d,
		CH_WILD, CH_WILD, CH_WILD, CH_WILD
	};

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [WILD_LEN-1:0][BYTE_W-1:0] wild_t;

	typedef struct packed {
		logic  care;
		byte_t ref_ch;
	} cell_cfg_t;

	function automatic cell_cfg_t cell_cfg(input int pos);
		cell_cfg_t c;
		c.ref_ch = PATTERN_TEXT[pos];
		c.care   = (PATTERN_TEXT[pos] != CH_WILD);
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/wst_if.sv =====
// Valid/ready channel interfaces for key bytes in and decoded results out.
// Depends on wst_pkg for the payload widths.
`default_nettype none

interface wst_key_if;
	logic                      valid;
	logic                      ready;
	logic [wst_pkg::BYTE_W-1:0] key_byte;

	modport source (output valid, output key_byte, input ready);
	modport sink (input valid, input key_byte, output ready);
endinterface

interface wst_res_if;
	logic                            valid;
	logic                            ready;
	logic signed [wst_pkg::RES_W-1:0] parameter_res;

	modport source (output valid, output parameter_res, input ready);
	modport sink (input valid, input parameter_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/wst_cell.sv =====
// One window cell: holds a byte, passes it on when the window shifts and
// compares the incoming byte with its pattern character. Depends on wst_pkg.
`default_nettype none

module wst_cell (
	input  wire logic               clk,
	input  wire logic               shift_en,
	input  wire wst_pkg::byte_t     d,
	input  wire wst_pkg::cell_cfg_t cfg,
	output wst_pkg::byte_t          q,
	output logic                    hit
);

	wst_pkg::byte_t byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= d;
		end
	end

	// The compare looks at the byte this cell will hold after the shift.
	assign hit = !cfg.care || (d == cfg.ref_ch);
	assign q   = byte_q;

endmodule

`default_nettype wire

// ===== rtl/wst_decode.sv =====
// Decodes a signed decimal value from the four wildcard bytes: leading
// spaces, an optional sign, then digits up to the first non-digit. Uses wst_pkg.
`default_nettype none

module wst_decode (
	input  wire wst_pkg::wild_t              wild,
	output logic signed [wst_pkg::RES_W-1:0] value
);

	localparam logic [1:0] PH_SPACE = 2'd0;
	localparam logic [1:0] PH_DIGIT = 2'd1;
	localparam logic [1:0] PH_DONE  = 2'd2;

	always_comb begin
		logic [1:0]                  phase;
		logic                        neg;
		logic [wst_pkg::ACC_W-1:0]   acc;
		wst_pkg::byte_t              b;
		logic                        is_dig;
		logic [wst_pkg::ACC_W-1:0]   dig;

		phase = PH_SPACE;
		neg   = 1'b0;
		acc   = '0;
		for (int i = 0; i < wst_pkg::WILD_LEN; i++) begin
			b      = wild[i];
			is_dig = (b >= wst_pkg::CH_ZERO) && (b <= wst_pkg::CH_NINE);
			dig    = wst_pkg::ACC_W'(b - wst_pkg::CH_ZERO);
			unique case (phase)
				PH_SPACE: begin
					if (b == wst_pkg::CH_SPACE) begin
						phase = PH_SPACE;
					end else if (b == wst_pkg::CH_PLUS || b == wst_pkg::CH_MINUS) begin
						neg   = (b == wst_pkg::CH_MINUS);
						phase = PH_DIGIT;
					end else if (is_dig) begin
						acc   = dig;
						phase = PH_DIGIT;
					end else begin
						phase = PH_DONE;
					end
				end
				PH_DIGIT: begin
					if (is_dig) begin
						acc = wst_pkg::ACC_W'(acc * wst_pkg::ACC_W'(10) + dig);
					end else begin
						phase = PH_DONE;
					end
				end
				default: begin
					phase = PH_DONE;
				end
			endcase
		end
		value = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
	end

endmodule

`default_nettype wire

// ===== rtl/wildcard_sequence_trigger.sv =====
// Wildcard sequence trigger: a row of ten byte cells watching for "system"
// followed by four wildcard bytes. Depends on wst_pkg, wst_if, wst_cell and
// wst_decode.
//
// Usage:
//   key: one key byte per beat. A zero byte is taken and ignored. Every other
//        byte shifts into the ten-cell window, newest at the far end.
//   res: one beat per detected sequence, carrying the signed value decoded
//        from the four wildcard bytes (-999..9999).
// When the window holds ten bytes whose oldest six spell "system", the fill
// count drops to zero and the wildcard bytes move to a decode stage; the
// value moves on to the output register once that register is free.
// Throughput is one key byte per cycle while key.ready is high. A stalled
// receiver holds the result; key beats keep flowing until a second finished
// result waits in the decode stage, then key.ready drops.
// Reset clears the fill count and both valid flags; window contents are not
// cleared, as bytes are only compared once ten new ones have arrived.
`default_nettype none

module wildcard_sequence_trigger (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wst_key_if.sink    key,
	wst_res_if.source  res
);

	wst_pkg::byte_t                 cell_q   [wst_pkg::PATTERN_LENGTH];
	wst_pkg::byte_t                 cell_d   [wst_pkg::PATTERN_LENGTH];
	logic [wst_pkg::PATTERN_LENGTH-1:0] hit;
	logic [wst_pkg::COUNT_W-1:0]    count_q;
	logic                           shift_en;
	logic                           full_next;
	logic                           match;
	logic                           s1_valid_s1;
	wst_pkg::wild_t                 wild_s1;
	logic                           s1_adv;
	logic signed [wst_pkg::RES_W-1:0] dec_value;
	logic                           out_valid_q;
	logic signed [wst_pkg::RES_W-1:0] out_res_q;

	assign s1_adv    = s1_valid_s1 && (!out_valid_q || res.ready);
	assign key.ready = !s1_valid_s1 || s1_adv;
	assign shift_en  = key.valid && key.ready && (key.key_byte != '0);

	for (genvar i = 0; i < wst_pkg::PATTERN_LENGTH; i++) begin : g_cell
		if (i == wst_pkg::PATTERN_LENGTH - 1) begin : g_last
			assign cell_d[i] = key.key_byte;
		end else begin : g_mid
			assign cell_d[i] = cell_q[i+1];
		end
		wst_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        (cell_d[i]),
			.cfg      (wst_pkg::cell_cfg(i)),
			.q        (cell_q[i]),
			.hit      (hit[i])
		);
	end

	// The window is full after this beat if it already held nine or ten bytes.
	assign full_next = count_q >= wst_pkg::COUNT_W'(wst_pkg::PATTERN_LENGTH - 1);
	assign match     = shift_en && full_next && (&hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (shift_en) begin
			if (match) begin
				count_q <= '0;
			end else if (count_q != wst_pkg::COUNT_W'(wst_pkg::PATTERN_LENGTH)) begin
				count_q <= count_q + wst_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (match) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			for (int j = 0; j < wst_pkg::WILD_LEN; j++) begin
				wild_s1[j] <= cell_d[wst_pkg::FIXED_PART + j];
			end
		end
	end

	wst_decode u_decode (
		.wild  (wild_s1),
		.value (dec_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_res_q <= dec_value;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.parameter_res = out_res_q;

endmodule

`default_nettype wire

// ===== rtl/wst_checker.sv =====
// Port-level checks on the wildcard sequence trigger, bound to its top level.
// Depends on wst_pkg and wildcard_sequence_trigger_macros.svh.
`default_nettype none
`include "wildcard_sequence_trigger_macros.svh"

module wst_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic [wst_pkg::BYTE_W-1:0]      in_byte,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic signed [wst_pkg::RES_W-1:0] out_res
);

	// A stalled result beat stays up with the same value.
	`WST_ASSERT_NEXT(a_res_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_res), "result changed while stalled")

	// Four wildcard bytes cannot decode outside -999..9999.
	`WST_ASSERT(a_res_range, clk, arst_n, out_valid |-> (out_res >= -15'sd999 && out_res <= 15'sd9999), "result out of range")

	// A new result must be preceded by a taken nonzero key beat that caused it.
	`WST_ASSERT(a_res_cause, clk, arst_n, $rose(out_valid) |-> $past(in_valid && in_ready && (in_byte != '0), 2), "result without a causing key beat")

endmodule

bind wildcard_sequence_trigger wst_checker u_wst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (key.valid),
	.in_ready  (key.ready),
	.in_byte   (key.key_byte),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_res   (res.parameter_res)
);

`default_nettype wire
